// ===== rtl/fvn3_pkg.sv =====
// Shared types, constants and helper functions for the fractal value noise block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package fvn3_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int LEVEL_MAX_DEF = 31;
   localparam int WORD_W        = 32;
   localparam int LEVEL_W       = 5;
   localparam int CSR_IDX_W     = 2;

   // Stage counts: octave unit, then term shift, two adder tree levels, final
   // sum and the normalizing output stage.
   localparam int OCT_STAGES    = 13;
   localparam int TOP_STAGES    = 5;
   localparam int PIPE_STAGES   = OCT_STAGES + TOP_STAGES;
   localparam int TERM_SLOTS    = 32;
   localparam int TREE_MID      = TERM_SLOTS / 4;
   localparam int TREE_TOP      = TREE_MID / 4;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED        = 2'd0,
      CSR_LEVEL_COUNT = 2'd1,
      CSR_START_LEVEL = 2'd2,
      CSR_RANGE_MODE  = 2'd3
   } csr_index_type;

   localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 5'd8;

   localparam word_type HASH_MUL_X = 32'd1619;
   localparam word_type HASH_MUL_Y = 32'd31337;
   localparam word_type HASH_MUL_Z = 32'd6971;
   localparam word_type HASH_MUL_S = 32'd1013;
   localparam word_type MIX_MUL    = 32'd60493;
   localparam word_type MIX_ADD    = 32'd19990303;
   localparam word_type MIX_OFFSET = 32'd1376312589;
   localparam word_type MID_RANGE  = 32'h7fffffff;
   localparam int       MIX_SHIFT  = 13;

   // Hash offset of a cube corner; bit 0 steps x, bit 1 steps y, bit 2 steps z.
   function automatic word_type corner_offset(input logic [2:0] corner);
      word_type acc;
      acc = '0;
      if (corner[0]) acc = acc + HASH_MUL_X;
      if (corner[1]) acc = acc + HASH_MUL_Y;
      if (corner[2]) acc = acc + HASH_MUL_Z;
      return acc;
   endfunction

   // Fold the hash about mid-range; odd corners keep the upper half.
   function automatic word_type parity_fold(input word_type h, input logic odd);
      word_type r;
      if (odd) begin
         r = (h > MID_RANGE) ? h : ~h;
      end else begin
         r = (h < MID_RANGE) ? h : ~h;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fvn3_octave.sv =====
// One octave of value noise: eight pipelined corner hashes and seven lerps.
// Depends on fvn3_pkg for constants and the hash helper functions.
`default_nettype none

module fvn3_octave #(
   parameter int FRAC_BITS = fvn3_pkg::FRAC_BITS_DEF,
   parameter int LEVEL     = 0
) (
   input  logic                            clock,
   input  logic [fvn3_pkg::OCT_STAGES-1:0] stage_en,
   input  fvn3_pkg::word_type              pos_x,
   input  fvn3_pkg::word_type              pos_y,
   input  fvn3_pkg::word_type              pos_z,
   input  fvn3_pkg::word_type              seed,
   output fvn3_pkg::word_type              oct_value,
   output fvn3_pkg::word_type              base_hash
);

   localparam int SHIFT  = LEVEL + FRAC_BITS;
   localparam int FRW    = 3 * FRAC_BITS;
   localparam int PROD_W = fvn3_pkg::WORD_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      fvn3_pkg::word_type   base;
      fvn3_pkg::word_type   diff;
      logic [FRAC_BITS:0]   fac;
   } prep_type;

   function automatic prep_type blend_prep(input fvn3_pkg::word_type a,
                                           input fvn3_pkg::word_type b,
                                           input logic [FRAC_BITS-1:0] f);
      prep_type p;
      if (a > b) begin
         p.base = b;
         p.diff = a - b;
         p.fac  = ONE - {1'b0, f};
      end else begin
         p.base = a;
         p.diff = b - a;
         p.fac  = {1'b0, f};
      end
      return p;
   endfunction

   function automatic fvn3_pkg::word_type blend_done(input prep_type p);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(p.diff) * PROD_W'(p.fac);
      return p.base + prod[FRAC_BITS +: fvn3_pkg::WORD_W];
   endfunction

   fvn3_pkg::word_type  lx, ly, lz;
   fvn3_pkg::word_type  cx_ff, cy_ff, cz_ff;
   fvn3_pkg::word_type  mx_ff, my_ff, mz_ff, ms_ff;
   fvn3_pkg::word_type  h2_ff [8];
   fvn3_pkg::word_type  h3_ff [8];
   fvn3_pkg::word_type  h4_ff [8];
   fvn3_pkg::word_type  sq_ff [8];
   fvn3_pkg::word_type  t_ff  [8];
   fvn3_pkg::word_type  r_ff  [8];
   fvn3_pkg::word_type  fl_ff [8];
   prep_type            xp_ff [4];
   fvn3_pkg::word_type  xr_ff [4];
   prep_type            zp_ff [2];
   fvn3_pkg::word_type  zr_ff [2];
   prep_type            yp_ff;
   fvn3_pkg::word_type  out_ff;
   logic [FRW-1:0]      fr_ff  [0:10];
   logic                par_ff [1:5];
   fvn3_pkg::word_type  bh_ff  [7:12];

   assign lx = pos_x >> LEVEL;
   assign ly = pos_y >> LEVEL;
   assign lz = pos_z >> LEVEL;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cx_ff    <= pos_x >> SHIFT;
         cy_ff    <= pos_y >> SHIFT;
         cz_ff    <= pos_z >> SHIFT;
         fr_ff[0] <= {lz[FRAC_BITS-1:0], ly[FRAC_BITS-1:0], lx[FRAC_BITS-1:0]};
      end
      for (int s = 1; s <= 10; s++) begin
         if (stage_en[s]) fr_ff[s] <= fr_ff[s-1];
      end
      if (stage_en[1]) begin
         mx_ff     <= cx_ff * fvn3_pkg::HASH_MUL_X;
         my_ff     <= cy_ff * fvn3_pkg::HASH_MUL_Y;
         mz_ff     <= cz_ff * fvn3_pkg::HASH_MUL_Z;
         ms_ff     <= seed * fvn3_pkg::HASH_MUL_S;
         par_ff[1] <= cx_ff[0] ^ cy_ff[0] ^ cz_ff[0];
      end
      for (int s = 2; s <= 5; s++) begin
         if (stage_en[s]) par_ff[s] <= par_ff[s-1];
      end
      for (int c = 0; c < 8; c++) begin
         if (stage_en[2]) begin
            h2_ff[c] <= (mx_ff + my_ff + mz_ff + ms_ff + fvn3_pkg::corner_offset(3'(c)))
                        ^ ((mx_ff + my_ff + mz_ff + ms_ff
                            + fvn3_pkg::corner_offset(3'(c))) >> fvn3_pkg::MIX_SHIFT);
         end
         if (stage_en[3]) begin
            sq_ff[c] <= h2_ff[c] * h2_ff[c];
            h3_ff[c] <= h2_ff[c];
         end
         if (stage_en[4]) begin
            t_ff[c]  <= sq_ff[c] * fvn3_pkg::MIX_MUL + fvn3_pkg::MIX_ADD;
            h4_ff[c] <= h3_ff[c];
         end
         if (stage_en[5]) begin
            r_ff[c] <= h4_ff[c] * t_ff[c] + fvn3_pkg::MIX_OFFSET;
         end
         if (stage_en[6]) begin
            fl_ff[c] <= fvn3_pkg::parity_fold(r_ff[c],
                           par_ff[5] ^ ^(3'(c)));
         end
      end
      // x lerps: pair j joins corners 2j and 2j+1 (j bit 0 is y, bit 1 is z).
      for (int j = 0; j < 4; j++) begin
         if (stage_en[7]) xp_ff[j] <= blend_prep(fl_ff[2*j], fl_ff[2*j+1],
                                                 fr_ff[6][FRAC_BITS-1:0]);
         if (stage_en[8]) xr_ff[j] <= blend_done(xp_ff[j]);
      end
      // z lerps: k = 0 is the lower y row, k = 1 the upper.
      for (int k = 0; k < 2; k++) begin
         if (stage_en[9])  zp_ff[k] <= blend_prep(xr_ff[k], xr_ff[k+2],
                                                  fr_ff[8][2*FRAC_BITS +: FRAC_BITS]);
         if (stage_en[10]) zr_ff[k] <= blend_done(zp_ff[k]);
      end
      if (stage_en[11]) yp_ff  <= blend_prep(zr_ff[0], zr_ff[1],
                                             fr_ff[10][FRAC_BITS +: FRAC_BITS]);
      if (stage_en[12]) out_ff <= blend_done(yp_ff);
      if (stage_en[7])  bh_ff[7] <= fl_ff[0];
      for (int s = 8; s <= 12; s++) begin
         if (stage_en[s]) bh_ff[s] <= bh_ff[s-1];
      end
   end

   assign oct_value = out_ff;
   assign base_hash = bh_ff[12];

endmodule

`default_nettype wire

// ===== rtl/fractal_value_noise_3d.sv =====
// Top level of the fractal value noise block: control registers, octave array,
// term scaling, adder tree and output stage. Depends on fvn3_pkg and fvn3_octave.
//
//   Channel   Direction  Ports                                   Moves
//   req       in         req_valid, req_stall, req_pos_x/y/z     one 3-D point request
//   rsp       out        rsp_valid, rsp_stall, rsp_noise_value   one 32-bit noise sample
//   csr       in         csr_write, csr_index, csr_data          one register write
//
// A request is taken every cycle unless req_stall is high; a sample passes through
// the 13-stage octave pipeline (hash multiplies and three lerp levels) and then
// five stages of term shifting, adder tree and normalization.
// Reset is synchronous and clears only the valid bits and the control registers.
// Each stage holds while the stage ahead of it is full and stalled, so a stall on
// rsp backs up only as far as the first empty stage; bubbles are squeezed out.
`default_nettype none

module fractal_value_noise_3d #(
   parameter int FRAC_BITS = fvn3_pkg::FRAC_BITS_DEF,
   parameter int LEVEL_MAX = fvn3_pkg::LEVEL_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fvn3_pkg::word_type             req_pos_x,
   input  fvn3_pkg::word_type             req_pos_y,
   input  fvn3_pkg::word_type             req_pos_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fvn3_pkg::word_type             rsp_noise_value,
   input  logic                           csr_write,
   input  logic [fvn3_pkg::CSR_IDX_W-1:0] csr_index,
   input  fvn3_pkg::word_type             csr_data
);

   localparam int N  = fvn3_pkg::PIPE_STAGES;
   localparam int OS = fvn3_pkg::OCT_STAGES;
   localparam int LW = fvn3_pkg::LEVEL_W;

   // Control registers.
   fvn3_pkg::word_type seed_ff;
   logic [LW-1:0]      level_count_ff;
   logic [LW-1:0]      start_level_ff;
   logic               range_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff        <= '0;
         level_count_ff <= fvn3_pkg::LEVEL_COUNT_RESET;
         start_level_ff <= '0;
         range_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         case (fvn3_pkg::csr_index_type'(csr_index))
            fvn3_pkg::CSR_SEED:        seed_ff        <= csr_data;
            fvn3_pkg::CSR_LEVEL_COUNT: level_count_ff <= csr_data[LW-1:0];
            fvn3_pkg::CSR_START_LEVEL: start_level_ff <= csr_data[LW-1:0];
            fvn3_pkg::CSR_RANGE_MODE:  range_mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Valid bits travel with the data. A stage loads when it is empty or when
   // the stage ahead of it loads in the same cycle.
   logic [N-1:0] v_ff;
   logic [N-1:0] v_in;
   logic [N-1:0] stage_en;

   always_comb begin
      stage_en[N-1] = !v_ff[N-1] || !rsp_stall;
      for (int k = N - 2; k >= 0; k--) begin
         stage_en[k] = !v_ff[k] || stage_en[k+1];
      end
   end

   assign v_in = {v_ff[N-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (stage_en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = v_ff[N-1];

   // Octave array: unit L works on the point shifted right by L.
   fvn3_pkg::word_type oct_w  [LEVEL_MAX];
   fvn3_pkg::word_type base_w [LEVEL_MAX];

   for (genvar lv = 0; lv < LEVEL_MAX; lv++) begin : g_oct
      fvn3_octave #(
         .FRAC_BITS (FRAC_BITS),
         .LEVEL     (lv)
      ) u_oct (
         .clock     (clock),
         .stage_en  (stage_en[OS-1:0]),
         .pos_x     (req_pos_x),
         .pos_y     (req_pos_y),
         .pos_z     (req_pos_z),
         .seed      (seed_ff),
         .oct_value (oct_w[lv]),
         .base_hash (base_w[lv])
      );
   end

   // Effective level count saturates at LEVEL_MAX. The user must change configuration
   // only while the pipeline is empty, which the block does not enforce; so reading it live is safe.
   logic [LW-1:0] levels;
   logic [LW-1:0] norm_shift;

   assign levels     = (32'(level_count_ff) > LEVEL_MAX) ? LW'(LEVEL_MAX) : level_count_ff;
   assign norm_shift = range_mode_ff ? (levels - start_level_ff) : levels;

   // Term stage: each octave is scaled down by (levels - L) and dropped when it
   // falls outside the active range. In full mode slot zero holds the base
   // corner hash instead of an octave.
   fvn3_pkg::word_type term_ff [fvn3_pkg::TERM_SLOTS];

   for (genvar i = 0; i < fvn3_pkg::TERM_SLOTS; i++) begin : g_term
      if (i < LEVEL_MAX) begin : g_live
         logic [LW-1:0]      lv5;
         logic               in_range;
         fvn3_pkg::word_type term_in;

         assign lv5 = LW'(i);

         always_comb begin
            if (range_mode_ff) begin
               in_range = (lv5 >= start_level_ff) && (lv5 < levels);
            end else begin
               in_range = (i != 0) && (lv5 < levels);
            end
            if (!range_mode_ff && (i == 0)) begin
               term_in = base_w[0] >> levels;
            end else if (in_range) begin
               term_in = oct_w[i] >> (levels - lv5);
            end else begin
               term_in = '0;
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[OS]) term_ff[i] <= term_in;
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            if (stage_en[OS]) term_ff[i] <= '0;
         end
      end
   end

   // Registered adder tree: four inputs per node in both tree levels, then a two-input final sum.
   fvn3_pkg::word_type mid_ff [fvn3_pkg::TREE_MID];
   fvn3_pkg::word_type top_ff [fvn3_pkg::TREE_TOP];
   fvn3_pkg::word_type res_ff;
   fvn3_pkg::word_type out_ff;

   always_ff @(posedge clock) begin
      for (int g = 0; g < fvn3_pkg::TREE_MID; g++) begin
         if (stage_en[OS+1]) begin
            mid_ff[g] <= term_ff[4*g] + term_ff[4*g+1] + term_ff[4*g+2] + term_ff[4*g+3];
         end
      end
      for (int g = 0; g < fvn3_pkg::TREE_TOP; g++) begin
         if (stage_en[OS+2]) begin
            top_ff[g] <= mid_ff[4*g] + mid_ff[4*g+1] + mid_ff[4*g+2] + mid_ff[4*g+3];
         end
      end
      if (stage_en[OS+3]) res_ff <= top_ff[0] + top_ff[1];
      // Self-normalizing term; in range mode with an empty range the sum is zero.
      if (stage_en[OS+4]) out_ff <= res_ff + (res_ff >> norm_shift);
   end

   assign rsp_noise_value = out_ff;

endmodule

`default_nettype wire

// ===== rtl/fvn3_checker.sv =====
// Port-level checks for the fractal value noise block, bound to its top level.
// Depends on fvn3_pkg for port types.
`default_nettype none

module fvn3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input fvn3_pkg::word_type             req_pos_x,
   input fvn3_pkg::word_type             req_pos_y,
   input fvn3_pkg::word_type             req_pos_z,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input fvn3_pkg::word_type             rsp_noise_value,
   input logic                           csr_write,
   input logic [fvn3_pkg::CSR_IDX_W-1:0] csr_index,
   input fvn3_pkg::word_type             csr_data
);

   // A held sample stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A held sample does not change.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_noise_value))
      else $error("rsp_noise_value changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("sample offered right after reset");

   // With the output stage empty, every stage can move, so requests flow.
   a_no_false_stall: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output stage");

endmodule

bind fractal_value_noise_3d fvn3_checker u_fvn3_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for fractal_value_noise_3d: random and directed point
// requests checked against a behavioral noise predictor. Depends on fvn3_pkg.
`default_nettype none

module tb_top;

   // Settings of the block's control registers, mirrored here.
   typedef struct {
      fvn3_pkg::word_type seed;
      logic [4:0]         levels;
      logic [4:0]         start;
      logic               ranged;
   } noise_cfg_type;

   // Scoreboard: predicts the noise sample for each accepted request and
   // checks each returned sample against the oldest prediction.
   class noise_board;
      fvn3_pkg::word_type pending[$];
      noise_cfg_type      cfg;
      int                 errors;

      function new();
         cfg.seed = '0;
         cfg.levels = fvn3_pkg::LEVEL_COUNT_RESET;
         cfg.start = '0;
         cfg.ranged = 1'b0;
         errors = 0;
      endfunction

      function fvn3_pkg::word_type corner_hash(fvn3_pkg::word_type x, fvn3_pkg::word_type y,
                                               fvn3_pkg::word_type z);
         fvn3_pkg::word_type h;
         h = 32'd1619 * x + 32'd31337 * y + 32'd6971 * z + 32'd1013 * cfg.seed;
         h = h ^ (h >> 13);
         h = h * (h * h * 32'd60493 + 32'd19990303) + 32'd1376312589;
         if ((x ^ y ^ z) & 32'd1) begin
            h = (h > 32'h7fffffff) ? h : 32'hffffffff - h;
         end else begin
            h = (h < 32'h7fffffff) ? h : 32'hffffffff - h;
         end
         return h;
      endfunction

      // Floor-rounded interpolation from a toward b by fraction f.
      function fvn3_pkg::word_type lerp(fvn3_pkg::word_type a, fvn3_pkg::word_type b,
                                        logic [31:0] f);
         logic [63:0] d;
         logic [63:0] p;
         if (a > b) begin
            d = 64'(a) - 64'(b);
            p = (d * (64'd16384 - 64'(f))) >> 14;
            return b + p[31:0];
         end else begin
            d = 64'(b) - 64'(a);
            p = (d * 64'(f)) >> 14;
            return a + p[31:0];
         end
      endfunction

      function fvn3_pkg::word_type octave(fvn3_pkg::word_type x, fvn3_pkg::word_type y,
                                          fvn3_pkg::word_type z);
         fvn3_pkg::word_type fx, fy, fz, n, f, t, b;
         fx = x & 32'h3fff;
         fy = y & 32'h3fff;
         fz = z & 32'h3fff;
         x = x >> 14;
         y = y >> 14;
         z = z >> 14;
         n = lerp(corner_hash(x, y, z), corner_hash(x + 1, y, z), fx);
         f = lerp(corner_hash(x, y, z + 1), corner_hash(x + 1, y, z + 1), fx);
         t = lerp(n, f, fz);
         n = lerp(corner_hash(x, y + 1, z), corner_hash(x + 1, y + 1, z), fx);
         f = lerp(corner_hash(x, y + 1, z + 1), corner_hash(x + 1, y + 1, z + 1), fx);
         b = lerp(n, f, fz);
         return lerp(t, b, fy);
      endfunction

      function fvn3_pkg::word_type noise_sample(fvn3_pkg::word_type px,
                                                fvn3_pkg::word_type py,
                                                fvn3_pkg::word_type pz);
         fvn3_pkg::word_type acc;
         int lv, levels;
         levels = cfg.levels;
         acc = '0;
         if (cfg.ranged) begin
            if (cfg.start < levels) begin
               for (lv = cfg.start; lv < levels; lv++)
                  acc += octave(px >> lv, py >> lv, pz >> lv) >> (levels - lv);
               acc += acc >> (levels - cfg.start);
            end
         end else begin
            acc = corner_hash(px >> 14, py >> 14, pz >> 14) >> levels;
            for (lv = 1; lv < levels; lv++)
               acc += octave(px >> lv, py >> lv, pz >> lv) >> (levels - lv);
            acc += acc >> levels;
         end
         return acc;
      endfunction

      function void note_request(fvn3_pkg::word_type px, fvn3_pkg::word_type py,
                                 fvn3_pkg::word_type pz);
         pending.push_back(noise_sample(px, py, pz));
      endfunction

      function void check_sample(fvn3_pkg::word_type got);
         fvn3_pkg::word_type want;
         if (pending.size() == 0) begin
            $error("unexpected sample noise_value=%h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $error("noise_value expected %h actual %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   fvn3_pkg::word_type req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   fvn3_pkg::word_type rsp_noise_value;
   logic               csr_write = 1'b0;
   logic [fvn3_pkg::CSR_IDX_W-1:0] csr_index = fvn3_pkg::CSR_SEED;
   fvn3_pkg::word_type csr_data = '0;

   noise_board board = new();

   // Idle percentages for each side; changed between phases.
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_off = 1'b0;
   int hold_cycles = 0;
   longint cycles = 0;

   fractal_value_noise_3d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: the slowest correct run is far below this many cycles.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Results are sampled at the rising edge, where the handshake completes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_sample(rsp_noise_value);
   end

   // The receiver decides its stall at the falling edge. A long hold-off is
   // counted here so that the pipeline fills and pushes back on requests.
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 60) begin
            hold_off <= 1'b0;
            hold_cycles <= 0;
         end
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Offer one point request, with random idle cycles, and wait until the
   // block takes it. The request stays offered into the next call, which
   // either replaces it or idles.
   task automatic send_point(fvn3_pkg::word_type x, fvn3_pkg::word_type y,
                             fvn3_pkg::word_type z);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(x, y, z);
      @(negedge clock);
   endtask

   // Wait until every predicted sample has come back, plus a drain margin.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // Register writes happen only while the pipeline is empty. The write
   // enable is dropped by the caller after the last write.
   task automatic write_reg(fvn3_pkg::csr_index_type idx, fvn3_pkg::word_type value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      case (idx)
         fvn3_pkg::CSR_SEED:        board.cfg.seed = value;
         fvn3_pkg::CSR_LEVEL_COUNT: board.cfg.levels = value[4:0];
         fvn3_pkg::CSR_START_LEVEL: board.cfg.start = value[4:0];
         fvn3_pkg::CSR_RANGE_MODE:  board.cfg.ranged = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(fvn3_pkg::word_type s, int lv, int st, bit rm);
      write_reg(fvn3_pkg::CSR_SEED, s);
      write_reg(fvn3_pkg::CSR_LEVEL_COUNT, fvn3_pkg::word_type'(lv));
      write_reg(fvn3_pkg::CSR_START_LEVEL, fvn3_pkg::word_type'(st));
      write_reg(fvn3_pkg::CSR_RANGE_MODE, fvn3_pkg::word_type'(rm));
      csr_write <= 1'b0;
   endtask

   // Random point: full-range words half the time, otherwise small or extreme values.
   function automatic fvn3_pkg::word_type rand_coord();
      case ($urandom_range(3))
         0: return $urandom_range(32'h3ffff);
         1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic random_burst(int n);
      repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset settings: corners of the coordinate space,
      // points on cell boundaries and fractions just below one.
      send_point('0, '0, '0);
      send_point('1, '1, '1);
      send_point(32'h0000_3fff, 32'h0000_4000, 32'h0000_7fff);
      send_point(32'hffff_c000, 32'h0000_0000, 32'hffff_ffff);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555);
      send_point(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      drain();

      // Full mode with a single level: only the base corner term.
      configure(32'hffff_ffff, 1, 0, 1'b0);
      send_point(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9);
      send_point('1, '0, '1);
      drain();
      // Full mode with zero levels: twice the base hash.
      configure(32'h0000_0001, 0, 0, 1'b0);
      send_point(32'h0001_c000, 32'h0002_4000, 32'hffff_ffff);
      drain();
      // Range mode: start at zero, start just below the count, start not below.
      configure(32'hdead_beef, 31, 0, 1'b1);
      send_point('1, '1, '1);
      send_point(32'h0000_2000, 32'h0000_1000, 32'h0000_0800);
      drain();
      configure(32'h1357_9bdf, 9, 8, 1'b1);
      send_point(32'h4000_0000, 32'h0003_ffff, 32'h0000_0001);
      drain();
      configure(32'h2468_ace0, 5, 5, 1'b1);
      send_point(32'h7777_7777, 32'h8888_8888, 32'h9999_9999);
      drain();
      configure(32'h0, 3, 31, 1'b1);
      send_point(32'h0000_c000, '1, 32'h0);
      drain();

      // Random phases: sender mostly busy and receiver mostly stalled,
      // then the reverse, then no idling, each under fresh settings.
      send_idle = 25;
      recv_idle = 86;
      configure($urandom, $urandom_range(1, 12), 0, 1'b0);
      random_burst(80);
      drain();
      configure($urandom, 31, $urandom_range(0, 31), 1'b1);
      random_burst(80);
      drain();

      send_idle = 86;
      recv_idle = 25;
      configure($urandom, $urandom_range(1, 31), $urandom_range(0, 8), 1'b1);
      random_burst(80);
      drain();
      configure($urandom, $urandom_range(0, 31), 0, 1'b0);
      random_burst(80);
      drain();

      send_idle = 0;
      recv_idle = 0;
      configure($urandom, $urandom_range(1, 16), $urandom_range(0, 4), 1'b0);
      // Long receiver hold-off while requests keep coming.
      hold_off <= 1'b1;
      random_burst(100);
      drain();
      configure($urandom, 8, 2, 1'b1);
      random_burst(80);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
